>>> hw/rtl/lcdtc_pkg.sv
// Shared types, op codes, defaults and the controller init table for the LCD text renderer.
`default_nettype none

package lcdtc_pkg;

    localparam int GLYPH_WIDTH_DEF = 5;
    localparam int GLYPH_COUNT_DEF = 224;
    localparam int FIRST_CODE_DEF  = 32;

    localparam logic [2:0] OP_RAW_CMD  = 3'd0;
    localparam logic [2:0] OP_RAW_DATA = 3'd1;
    localparam logic [2:0] OP_LOAD     = 3'd2;
    localparam logic [2:0] OP_CHAR     = 3'd3;
    localparam logic [2:0] OP_ULINE    = 3'd4;
    localparam logic [2:0] OP_CURSOR   = 3'd5;
    localparam logic [2:0] OP_INIT     = 3'd6;

    localparam logic [7:0] ROW_CMD_BASE   = 8'h40;
    localparam logic [7:0] COL_CMD_BASE   = 8'h80;
    localparam logic [7:0] CELL_PITCH     = 8'd7;
    localparam logic [7:0] UNDERLINE_MASK = 8'h80;
    localparam logic [7:0] BLANK_COLUMN   = 8'h00;
    localparam logic [2:0] INIT_LAST      = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] byte_value;
        logic [7:0] char_code;
        logic [2:0] glyph_column;
        logic [2:0] text_row;
        logic [3:0] text_col;
    } in_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] out_byte;
        logic       last;
    } out_t;

    // Power-up command sequence for the display controller.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h21;
            3'd1:    b = 8'hB1;
            3'd2:    b = 8'h04;
            3'd3:    b = 8'h14;
            3'd4:    b = 8'hB8;
            3'd5:    b = 8'h20;
            3'd6:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcd_text_cell_renderer.sv
// Usage: text operations for an 84x48 monochrome LCD come in on the op channel
// (op_valid, op_stall, op_item) and leave as command or data bytes on the res channel
// (res_valid, res_stall, res_item), one item per byte, with last set on the final
// byte of each operation. Load items write one glyph column into the glyph store and
// produce no byte, so loads can be taken back to back. Any other item holds the input
// from the cycle in which it is taken until its last byte is loaded, at one byte a cycle
// while the receiver does not stall, with glyph columns read from the store in sequence
// through one address counter. The item is first registered into the sequencer state,
// and its first byte is loaded into the output register from there. One operation is
// worked at a time: op_stall is high until its last byte has been loaded into the
// output register, so the next item can enter while that byte still waits to be
// taken. When the receiver stalls, the output register holds its byte and the sequencer
// waits. Reset empties the output register and returns the sequencer to idle; the glyph
// store is not cleared, and characters must be loaded before they are drawn.
`default_nettype none

module lcd_text_cell_renderer #(
    parameter int GLYPH_WIDTH = lcdtc_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_COUNT = lcdtc_pkg::GLYPH_COUNT_DEF,
    parameter int FIRST_CODE  = lcdtc_pkg::FIRST_CODE_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             op_valid,
    output logic                  op_stall,
    input  wire lcdtc_pkg::in_t   op_item,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output lcdtc_pkg::out_t       res_item
);

    localparam int DEPTH = GLYPH_WIDTH * GLYPH_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(GLYPH_WIDTH + 3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW,
        ST_CHAR,
        ST_CURSOR,
        ST_INIT
    } state_t;

    state_t          state_reg, state_next;
    lcdtc_pkg::in_t  item_reg, item_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic            glyph_ok_reg, glyph_ok_next;
    logic            res_valid_reg, res_valid_next;
    lcdtc_pkg::out_t res_item_reg, res_item_next;

    logic            accept;
    logic            slot_free;
    logic            emit;
    lcdtc_pkg::out_t emit_item;
    logic            code_in_store;
    logic [7:0]      code_off;
    logic [AW-1:0]   cell_base;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic [7:0]      rd_data;
    logic [7:0]      mark;

    assign op_stall  = (state_reg != ST_IDLE);
    assign accept    = op_valid && !op_stall;
    assign slot_free = !res_valid_reg || !res_stall;

    assign code_in_store = ({1'b0, op_item.char_code} >= 9'(FIRST_CODE)) &&
                           ({1'b0, op_item.char_code} < 9'(FIRST_CODE + GLYPH_COUNT));
    assign code_off  = 8'(op_item.char_code - 8'(FIRST_CODE));
    assign cell_base = AW'(AW'(code_off) * AW'(GLYPH_WIDTH));
    assign wr_addr   = AW'(cell_base + AW'(op_item.glyph_column));
    assign wr_en     = accept && (op_item.op == lcdtc_pkg::OP_LOAD) && code_in_store &&
                       (4'(op_item.glyph_column) < 4'(GLYPH_WIDTH));

    assign mark = (item_reg.op == lcdtc_pkg::OP_ULINE) ? lcdtc_pkg::UNDERLINE_MASK
                                                        : lcdtc_pkg::BLANK_COLUMN;

    lcdtc_glyph_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (op_item.byte_value),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Byte that the current step produces, and the glyph read issued alongside it.
    always_comb
    begin
        emit      = 1'b0;
        rd_en     = 1'b0;
        emit_item = '0;
        case (state_reg)
            ST_RAW:
            begin
                emit               = slot_free;
                emit_item.is_data  = (item_reg.op == lcdtc_pkg::OP_RAW_DATA);
                emit_item.out_byte = item_reg.byte_value;
                emit_item.last     = 1'b1;
            end
            ST_CURSOR:
            begin
                emit = slot_free;
                if (cnt_reg == '0)
                begin
                    emit_item.out_byte = 8'(lcdtc_pkg::ROW_CMD_BASE + 8'(item_reg.text_row));
                end
                else
                begin
                    emit_item.out_byte = 8'(lcdtc_pkg::COL_CMD_BASE +
                                            8'(8'(item_reg.text_col) * lcdtc_pkg::CELL_PITCH));
                    emit_item.last     = 1'b1;
                end
            end
            ST_INIT:
            begin
                emit               = slot_free;
                emit_item.out_byte = lcdtc_pkg::init_byte(cnt_reg[2:0]);
                emit_item.last     = (cnt_reg[2:0] == lcdtc_pkg::INIT_LAST);
            end
            ST_CHAR:
            begin
                emit              = slot_free;
                emit_item.is_data = 1'b1;
                if (cnt_reg == '0)
                begin
                    emit_item.out_byte = lcdtc_pkg::BLANK_COLUMN;
                end
                else if (cnt_reg <= CNT_W'(GLYPH_WIDTH))
                begin
                    emit_item.out_byte = (glyph_ok_reg ? rd_data : lcdtc_pkg::BLANK_COLUMN) | mark;
                end
                else
                begin
                    emit_item.out_byte = lcdtc_pkg::BLANK_COLUMN;
                    emit_item.last     = 1'b1;
                end
                // The column shown at step k+1 is fetched while step k goes out.
                rd_en = slot_free && (cnt_reg < CNT_W'(GLYPH_WIDTH));
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        glyph_ok_next  = glyph_ok_reg;
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (emit)
        begin
            res_valid_next = 1'b1;
            res_item_next  = emit_item;
            cnt_next       = CNT_W'(cnt_reg + 1'b1);
            if (emit_item.last)
            begin
                state_next = ST_IDLE;
            end
        end
        if (rd_en)
        begin
            addr_next = AW'(addr_reg + 1'b1);
        end

        if (accept)
        begin
            item_next     = op_item;
            cnt_next      = '0;
            addr_next     = code_in_store ? cell_base : '0;
            glyph_ok_next = code_in_store;
            case (op_item.op)
                lcdtc_pkg::OP_RAW_CMD,
                lcdtc_pkg::OP_RAW_DATA: state_next = ST_RAW;
                lcdtc_pkg::OP_CHAR,
                lcdtc_pkg::OP_ULINE:    state_next = ST_CHAR;
                lcdtc_pkg::OP_CURSOR:   state_next = ST_CURSOR;
                lcdtc_pkg::OP_INIT:     state_next = ST_INIT;
                default:                state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            glyph_ok_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            glyph_ok_reg  <= glyph_ok_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // A character item starts the character sequence on the next cycle.
    a_char_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op_item.op == lcdtc_pkg::OP_CHAR || op_item.op == lcdtc_pkg::OP_ULINE)
        |=> state_reg == ST_CHAR)
        else $error("character item did not start the character sequence");

    // Loading the final byte of an operation frees the sequencer.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_item.last |=> state_reg == ST_IDLE)
        else $error("sequencer busy after the final byte");

    // The step count of a character never runs past the trailing blank column.
    a_char_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHAR |-> cnt_reg <= CNT_W'(GLYPH_WIDTH + 1))
        else $error("character step count out of range");

    // The glyph store is written only between operations.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ST_IDLE && !rd_en)
        else $error("glyph store written during an operation");

endmodule

`default_nettype wire

>>> hw/rtl/lcdtc_glyph_mem.sv
// Glyph column store: one write port, one registered read port.
`default_nettype none

module lcdtc_glyph_mem #(
    parameter int DEPTH = lcdtc_pkg::GLYPH_WIDTH_DEF * lcdtc_pkg::GLYPH_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/lcd_byte_checker.sv
// Channel monitor that predicts the LCD byte stream of the text renderer and checks every byte.
module lcd_byte_checker #(
    parameter int GLYPH_WIDTH = lcdtc_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_COUNT = lcdtc_pkg::GLYPH_COUNT_DEF,
    parameter int FIRST_CODE  = lcdtc_pkg::FIRST_CODE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    input  logic            op_stall,
    input  lcdtc_pkg::in_t  op_item,
    input  logic            res_valid,
    input  logic            res_stall,
    input  lcdtc_pkg::out_t res_item,
    output int              errors,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcdtc_pkg::*;

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_WIDTH;
    localparam logic [0:6][7:0] POWER_UP_CMDS =
        {8'h21, 8'hB1, 8'h04, 8'h14, 8'hB8, 8'h20, 8'h0C};

    logic [7:0] glyph_mem [0:STORE_DEPTH-1];
    out_t       expected_bytes [$];
    int         fail_count = 0;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic out_t lcd_byte(input logic d, input logic [7:0] b, input logic l);
        out_t r;
        r.is_data  = d;
        r.out_byte = b;
        r.last     = l;
        return r;
    endfunction

    function automatic bit code_stored(input logic [7:0] code);
        return int'(code) >= FIRST_CODE && int'(code) < FIRST_CODE + GLYPH_COUNT;
    endfunction

    // Appends the bytes that one accepted item makes; loads only update the glyph store.
    task automatic predict_lcd_bytes(input in_t it);
        logic [7:0] mark;
        logic [7:0] column;
        int         base;
        case (it.op)
            OP_RAW_CMD:  expected_bytes.push_back(lcd_byte(1'b0, it.byte_value, 1'b1));
            OP_RAW_DATA: expected_bytes.push_back(lcd_byte(1'b1, it.byte_value, 1'b1));
            OP_LOAD:
            begin
                if (code_stored(it.char_code) && int'(it.glyph_column) < GLYPH_WIDTH)
                    glyph_mem[(int'(it.char_code) - FIRST_CODE) * GLYPH_WIDTH
                              + int'(it.glyph_column)] = it.byte_value;
            end
            OP_CHAR, OP_ULINE:
            begin
                mark = (it.op == OP_ULINE) ? UNDERLINE_MASK : BLANK_COLUMN;
                base = (int'(it.char_code) - FIRST_CODE) * GLYPH_WIDTH;
                expected_bytes.push_back(lcd_byte(1'b1, BLANK_COLUMN, 1'b0));
                for (int i = 0; i < GLYPH_WIDTH; i++)
                begin
                    if (code_stored(it.char_code))
                        column = glyph_mem[base + i];
                    else
                        column = BLANK_COLUMN;
                    expected_bytes.push_back(lcd_byte(1'b1, column | mark, 1'b0));
                end
                expected_bytes.push_back(lcd_byte(1'b1, BLANK_COLUMN, 1'b1));
            end
            OP_CURSOR:
            begin
                expected_bytes.push_back(lcd_byte(1'b0, ROW_CMD_BASE + 8'(it.text_row), 1'b0));
                expected_bytes.push_back(
                    lcd_byte(1'b0, COL_CMD_BASE + CELL_PITCH * 8'(it.text_col), 1'b1));
            end
            OP_INIT:
            begin
                for (int k = 0; k < 7; k++)
                    expected_bytes.push_back(lcd_byte(1'b0, POWER_UP_CMDS[k], k == 6));
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin : watch
        out_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte is_data=%0b out_byte=%02h last=%0b",
                             $time, res_item.is_data, res_item.out_byte, res_item.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (res_item !== want)
                    begin
                        if (res_item.is_data !== want.is_data)
                            $display("%0t: is_data expected %0b, got %0b",
                                     $time, want.is_data, res_item.is_data);
                        if (res_item.out_byte !== want.out_byte)
                            $display("%0t: out_byte expected %02h, got %02h",
                                     $time, want.out_byte, res_item.out_byte);
                        if (res_item.last !== want.last)
                            $display("%0t: last expected %0b, got %0b",
                                     $time, want.last, res_item.last);
                        fail_count++;
                    end
                end
            end
            if (op_valid && !op_stall)
                predict_lcd_bytes(op_item);
        end
        errors  <= fail_count;
        pending <= expected_bytes.size();
    end

endmodule

>>> tb/sv/tb.sv
// Top of the LCD text renderer bench: clock, reset, item stimulus, output stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdtc_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int GLYPH_W      = GLYPH_WIDTH_DEF;
    localparam int GLYPH_N      = GLYPH_COUNT_DEF;
    localparam int CODE_BASE    = FIRST_CODE_DEF;
    localparam int STORE_DEPTH  = GLYPH_N * GLYPH_W;
    localparam int RANDOM_ITEMS = 95;
    localparam int IDLE_LIMIT   = 1000;

    logic clk = 1'b0;
    logic rst_n;
    logic op_valid;
    logic op_stall;
    in_t  op_item;
    logic res_valid;
    logic res_stall;
    out_t res_item;
    int   errors;
    int   pending;

    int         idle_cycles = 0;
    int         stall_left  = 0;
    bit         col_written [0:STORE_DEPTH-1];
    bit         code_ready  [0:255];
    logic [7:0] drawable_codes [$];

    always #6 clk = ~clk;

    lcd_text_cell_renderer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_item   (op_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    lcd_byte_checker byte_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_item   (op_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .errors    (errors),
        .pending   (pending)
    );

    // Receiver back-pressure: mostly short bursts, now and then a long stall or a clean stretch.
    always @(posedge clk)
    begin : receiver_stall
        int r;
        if (stall_left > 0)
            stall_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                res_stall  <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else if (r < 80)
            begin
                res_stall  <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else if (r < 92)
            begin
                res_stall  <= 1'b0;
                stall_left = $urandom_range(20, 60);
            end
            else
            begin
                res_stall  <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((op_valid && !op_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic in_t random_fields();
        in_t it;
        it.op           = 3'($urandom);
        it.byte_value   = 8'($urandom);
        it.char_code    = 8'($urandom);
        it.glyph_column = 3'($urandom);
        it.text_row     = 3'($urandom);
        it.text_col     = 4'($urandom);
        return it;
    endfunction

    // Tracks which glyphs are complete so that only written store entries get drawn.
    task automatic note_load(input in_t it);
        int  base;
        bit  full;
        if (it.op == OP_LOAD && int'(it.char_code) >= CODE_BASE
            && int'(it.char_code) < CODE_BASE + GLYPH_N && int'(it.glyph_column) < GLYPH_W)
        begin
            base = (int'(it.char_code) - CODE_BASE) * GLYPH_W;
            col_written[base + int'(it.glyph_column)] = 1'b1;
            full = 1'b1;
            for (int c = 0; c < GLYPH_W; c++)
                full &= col_written[base + c];
            if (full && !code_ready[it.char_code])
            begin
                code_ready[it.char_code] = 1'b1;
                drawable_codes.push_back(it.char_code);
            end
        end
    endtask

    // Holds the item on the channel until it is taken, then maybe idles.
    task automatic send_item(input in_t it);
        int gap;
        op_item  <= it;
        op_valid <= 1'b1;
        do
            @(posedge clk);
        while (op_stall);
        note_load(it);
        gap = pick_gap();
        if (gap > 0)
        begin
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [2:0] op, input logic [7:0] bv, input logic [7:0] code,
                         input logic [2:0] gcol, input logic [2:0] row, input logic [3:0] col);
        in_t it;
        it.op           = op;
        it.byte_value   = bv;
        it.char_code    = code;
        it.glyph_column = gcol;
        it.text_row     = row;
        it.text_col     = col;
        send_item(it);
    endtask

    task automatic settle();
        op_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic draw_random();
        in_t it;
        it    = random_fields();
        it.op = $urandom_range(0, 1) ? OP_ULINE : OP_CHAR;
        if (drawable_codes.size() > 0 && $urandom_range(0, 4) != 0)
            it.char_code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
        else
            it.char_code = 8'($urandom_range(0, CODE_BASE - 1));
        send_item(it);
    endtask

    initial
    begin : stimulus
        in_t        it;
        int         useful;
        int         r;
        logic [7:0] code;

        rst_n     <= 1'b0;
        op_valid  <= 1'b0;
        op_item   <= '0;
        res_stall <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_INIT,     8'h00, 8'h00, 3'd0, 3'd0, 4'd0);
        issue(OP_RAW_CMD,  8'h00, 8'h00, 3'd0, 3'd0, 4'd0);
        issue(OP_RAW_CMD,  8'hFF, 8'hFF, 3'd7, 3'd7, 4'd15);
        issue(OP_RAW_DATA, 8'hFF, 8'h00, 3'd0, 3'd0, 4'd0);
        issue(OP_RAW_DATA, 8'h00, 8'hFF, 3'd7, 3'd7, 4'd15);
        issue(OP_CURSOR,   8'h00, 8'h00, 3'd0, 3'd0, 4'd0);
        issue(OP_CURSOR,   8'h00, 8'h00, 3'd0, 3'd5, 4'd11);
        // Row and column beyond the panel are sent unchecked.
        issue(OP_CURSOR,   8'hFF, 8'hFF, 3'd7, 3'd7, 4'd15);
        issue(OP_LOAD, 8'hFF, 8'h20, 3'd0, 3'd0, 4'd0);
        issue(OP_LOAD, 8'h00, 8'h20, 3'd1, 3'd0, 4'd0);
        issue(OP_LOAD, 8'hAA, 8'h20, 3'd2, 3'd0, 4'd0);
        issue(OP_LOAD, 8'h55, 8'h20, 3'd3, 3'd0, 4'd0);
        issue(OP_LOAD, 8'h81, 8'h20, 3'd4, 3'd0, 4'd0);
        issue(OP_LOAD, 8'h7E, 8'hFF, 3'd0, 3'd7, 4'd15);
        issue(OP_LOAD, 8'h01, 8'hFF, 3'd1, 3'd7, 4'd15);
        issue(OP_LOAD, 8'h80, 8'hFF, 3'd2, 3'd7, 4'd15);
        issue(OP_LOAD, 8'h3C, 8'hFF, 3'd3, 3'd7, 4'd15);
        issue(OP_LOAD, 8'hFF, 8'hFF, 3'd4, 3'd7, 4'd15);
        // Loads past the glyph width or below the first code must leave the store alone.
        issue(OP_LOAD, 8'h00, 8'h20, 3'd5, 3'd0, 4'd0);
        issue(OP_LOAD, 8'h00, 8'hFF, 3'd7, 3'd0, 4'd0);
        issue(OP_LOAD, 8'hFF, 8'h1F, 3'd0, 3'd0, 4'd0);
        issue(OP_CHAR,  8'h00, 8'h20, 3'd0, 3'd0, 4'd0);
        issue(OP_ULINE, 8'h00, 8'h20, 3'd0, 3'd0, 4'd0);
        issue(OP_CHAR,  8'hFF, 8'hFF, 3'd7, 3'd7, 4'd15);
        issue(OP_ULINE, 8'hFF, 8'hFF, 3'd7, 3'd7, 4'd15);
        issue(OP_CHAR,  8'h00, 8'h00, 3'd0, 3'd0, 4'd0);
        issue(OP_ULINE, 8'hFF, 8'h1F, 3'd7, 3'd7, 4'd15);
        issue(OP_UNUSED, 8'hFF, 8'hFF, 3'd7, 3'd7, 4'd15);

        // Let the block run dry before the random part starts.
        settle();

        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                code = 8'($urandom_range(CODE_BASE, CODE_BASE + GLYPH_N - 1));
                for (int c = 0; c < GLYPH_W; c++)
                begin
                    it              = random_fields();
                    it.op           = OP_LOAD;
                    it.char_code    = code;
                    it.glyph_column = 3'(c);
                    send_item(it);
                end
                useful += GLYPH_W;
                if ($urandom_range(0, 1))
                begin
                    it           = random_fields();
                    it.op        = $urandom_range(0, 1) ? OP_ULINE : OP_CHAR;
                    it.char_code = code;
                    send_item(it);
                    useful++;
                end
            end
            else if (r < 48)
            begin
                draw_random();
                useful++;
            end
            else if (r < 58)
            begin
                it    = random_fields();
                it.op = OP_CURSOR;
                send_item(it);
                useful++;
            end
            else if (r < 64)
            begin
                it    = random_fields();
                it.op = OP_INIT;
                send_item(it);
                useful++;
            end
            else if (r < 77)
            begin
                it    = random_fields();
                it.op = $urandom_range(0, 1) ? OP_RAW_DATA : OP_RAW_CMD;
                send_item(it);
                useful++;
            end
            else if (r < 83 && drawable_codes.size() > 0)
            begin
                // Rewrite one column of a glyph already complete, then draw it.
                it              = random_fields();
                it.op           = OP_LOAD;
                it.char_code    = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
                it.glyph_column = 3'($urandom_range(0, GLYPH_W - 1));
                send_item(it);
                it.op = $urandom_range(0, 1) ? OP_ULINE : OP_CHAR;
                send_item(it);
                useful += 2;
            end
            else if (r < 92)
            begin
                it = random_fields();
                case ($urandom_range(0, 2))
                    0:
                    begin
                        it.op = OP_UNUSED;
                    end
                    1:
                    begin
                        it.op           = OP_LOAD;
                        it.glyph_column = 3'($urandom_range(GLYPH_W, 7));
                    end
                    default:
                    begin
                        it.op        = OP_LOAD;
                        it.char_code = 8'($urandom_range(0, CODE_BASE - 1));
                    end
                endcase
                send_item(it);
            end
            else if (r < 95)
                settle();
            else
            begin
                draw_random();
                useful++;
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lcdtc_pkg.sv
hw/rtl/lcdtc_glyph_mem.sv
hw/rtl/lcd_text_cell_renderer.sv
tb/sv/lcd_byte_checker.sv
tb/sv/tb.sv
